// File: sv/cigsm_pkg.sv
// Package for the case-insensitive glob / substring name matcher.
// Holds character codes, register indexes, the cell control struct and the case fold.
// No dependencies.
`timescale 1ns / 1ps

package cigsm_pkg;

  localparam int PAT_MAX_DEF   = 32;
  localparam int NUM_PAT_WORDS = 4;
  localparam int WORD_W        = 64;
  localparam int PLEN_W        = 6;
  localparam int CFG_IDX_W     = 3;
  localparam int BYTE_W        = 8;

  localparam logic [BYTE_W-1:0] STAR_CHAR  = 8'h2A;
  localparam logic [BYTE_W-1:0] QMARK_CHAR = 8'h3F;
  localparam logic [BYTE_W-1:0] CASE_BIT   = 8'h20;
  localparam logic [BYTE_W-1:0] UPPER_A    = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_Z    = 8'h5A;
  localparam logic [BYTE_W-1:0] NUL_CHAR   = 8'h00;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_WILDCARD_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_W0    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_W1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_W2    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_W3    = 3'd5;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic              glob;   // whole-name glob mode
    logic              load;   // reload length enables and start state after reset or a config change
    logic              step;   // a name byte is transferred this cycle
    logic              last;   // that byte ends the name
    logic [BYTE_W-1:0] fc;     // folded name byte
    logic [PLEN_W-1:0] plen;   // programmed pattern length
  } cell_ctrl_t;

  function automatic logic [BYTE_W-1:0] fold_letter(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= UPPER_A && c <= UPPER_Z) r = c | CASE_BIT;
    return r;
  endfunction

endpackage

// File: sv/cigsm_cell.sv
// One pattern position of the matcher chain: active bit, enable bit, byte compare.
// Hands the advance/closure bit, the leading-star bit and the length enable to its neighbor.
// Depends on cigsm_pkg.
`timescale 1ns / 1ps

module cigsm_cell import cigsm_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  logic [BYTE_W-1:0] pat_byte,
  input  logic              chain_in,     // new active bit for this position from the left
  input  logic              lead_in,      // start state bit for this position
  input  logic              en_chain_in,  // all positions to the left are inside the pattern
  input  logic              en_right,     // neighbor's enable
  output logic              chain_out,
  output logic              lead_out,
  output logic              en_chain_out,
  output logic              en,
  output logic              tail          // this is the last pattern byte and it completes
);

  localparam logic [PLEN_W-1:0] IDX_L = PLEN_W'(IDX);

  logic act;
  logic is_star;
  logic is_qmark;
  logic is_eq;
  logic pos;
  logic adv;
  logic cls;

  always_comb begin
    is_star  = (pat_byte == STAR_CHAR);
    is_qmark = (pat_byte == QMARK_CHAR);
    is_eq    = (fold_letter(pat_byte) == ctrl.fc);
    // a star keeps its own position alive in glob mode
    pos      = chain_in | (ctrl.glob & act & en & is_star);
    if (ctrl.glob) begin
      adv = act & en & ~is_star & (is_qmark | is_eq);
    end else begin
      adv = act & en & is_eq;
    end
    // star closure: an active star position also activates the next one
    cls          = ctrl.glob & pos & en & is_star;
    chain_out    = adv | cls;
    lead_out     = lead_in & ctrl.glob & en & is_star;
    tail         = en & ~en_right & chain_out;
    en_chain_out = en_chain_in & (ctrl.plen > IDX_L) & (pat_byte != NUL_CHAR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
      en  <= 1'b0;
    end else if (ctrl.load) begin
      en  <= en_chain_out;
      act <= lead_in;
    end else if (ctrl.step) begin
      act <= ctrl.last ? lead_in : pos;
    end
  end

endmodule

// File: sv/case_insensitive_glob_or_substring_match.sv
// Top level of the case-insensitive glob / substring name matcher.
// Holds the config registers, the cell chain and the result registers.
// Depends on cigsm_pkg and cigsm_cell.
//
// Usage:
//   Name bytes arrive on the s_ stream, one per transfer; s_tlast marks the final
//   byte of a name. After that byte one result transfer leaves on the m_ stream,
//   m_tdata bit 0 = 1 on a match. Bytes without tlast give no result.
//   Config writes go over the cfg_ port (index 0 mode, 1 length, 2..5 pattern
//   words) and are meant only while no name is in progress. A write to a known
//   index restarts the name and holds s_tready low while the cell chain reloads
//   its length enables and start state. The result is registered and, unless an
//   earlier result is still held, valid the cycle after the last byte is taken.
//   Throughput: one byte per cycle while s_tready is high; every cell updates
//   its position in the same cycle, the longest path being the star-closure
//   ripple through PAT_MAX cells. A result held up by m_tready low parks the
//   next result in a skid register, so bytes keep flowing until a second name
//   ends; s_tready then stays low until the receiver takes the first result.
//   s_tready never looks at m_tready. Reset: registers clear (substring mode,
//   empty pattern) and the chain loads its start state before the first byte is taken.
`timescale 1ns / 1ps

module case_insensitive_glob_or_substring_match import cigsm_pkg::*; #(
  parameter int PAT_MAX = PAT_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [BYTE_W-1:0]    s_tdata,    // [7:0] text_byte
  input  logic                 s_tlast,    // last_byte
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [BYTE_W-1:0]    m_tdata,    // [0] matched, [7:1] zero
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  logic                    wildcard_mode;
  logic [PLEN_W-1:0]       pattern_length;
  logic [WORD_W-1:0]       pattern_word [NUM_PAT_WORDS];
  logic [1:0]              settle;
  logic                    found;
  logic                    matched;
  logic                    skid_valid;
  logic                    skid_matched;
  logic                    res_new;
  logic                    res_fire;
  logic                    out_fire;
  logic                    cfg_known;
  logic                    cfg_fire;
  logic                    in_fire;
  logic                    tail_any;
  cell_ctrl_t              ctrl;

  logic [PAT_MAX:0]        chain;
  logic [PAT_MAX:0]        lead;
  logic [PAT_MAX:0]        en_chain;
  logic [PAT_MAX:0]        en_vec;
  logic [PAT_MAX-1:0]      tail;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign s_tready  = (settle == 2'd0) & ~skid_valid;
  assign in_fire   = s_tvalid & s_tready;
  assign res_fire  = in_fire & s_tlast;
  assign out_fire  = m_tvalid & m_tready;
  assign m_tdata   = {{(BYTE_W-1){1'b0}}, matched};
  assign tail_any  = |tail;
  assign res_new   = wildcard_mode ? tail_any : (found | tail_any);

  always_comb begin
    unique case (cfg_index)
      REG_WILDCARD_MODE, REG_PATTERN_LEN, REG_PATTERN_W0,
      REG_PATTERN_W1, REG_PATTERN_W2, REG_PATTERN_W3: cfg_known = 1'b1;
      default:                                        cfg_known = 1'b0;
    endcase
  end

  always_comb begin
    ctrl.glob = wildcard_mode;
    ctrl.load = (settle != 2'd0);
    ctrl.step = in_fire;
    ctrl.last = s_tlast;
    ctrl.fc   = fold_letter(s_tdata);
    ctrl.plen = pattern_length;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wildcard_mode  <= 1'b0;
      pattern_length <= '0;
      for (int w = 0; w < NUM_PAT_WORDS; w++) pattern_word[w] <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_WILDCARD_MODE: wildcard_mode   <= cfg_data[0];
        REG_PATTERN_LEN:   pattern_length  <= cfg_data[PLEN_W-1:0];
        REG_PATTERN_W0:    pattern_word[0] <= cfg_data;
        REG_PATTERN_W1:    pattern_word[1] <= cfg_data;
        REG_PATTERN_W2:    pattern_word[2] <= cfg_data;
        REG_PATTERN_W3:    pattern_word[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // settle: chain reloads enables, then the start state that depends on them
  always_ff @(posedge clk) begin
    if (rst) begin
      settle     <= SETTLE_CYCLES;
      found      <= 1'b0;
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (cfg_fire && cfg_known) begin
        settle <= SETTLE_CYCLES;
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
      if (settle != 2'd0) begin
        found <= 1'b0;
      end else if (in_fire) begin
        found <= s_tlast ? 1'b0 : (found | (tail_any & ~wildcard_mode));
      end
      // skid only fills while m_tvalid is held, so it never overflows
      if (out_fire) begin
        m_tvalid   <= skid_valid | res_fire;
        skid_valid <= 1'b0;
      end else if (res_fire) begin
        m_tvalid   <= 1'b1;
        skid_valid <= m_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !m_tvalid) begin
      matched <= skid_valid ? skid_matched : res_new;
    end
    if (res_fire && m_tvalid && !out_fire) begin
      skid_matched <= res_new;
    end
  end

  // position 0 is always live in substring mode; start state begins at position 0
  assign chain[0]        = ~wildcard_mode;
  assign lead[0]         = 1'b1;
  assign en_chain[0]     = 1'b1;
  assign en_vec[PAT_MAX] = 1'b0;

  for (genvar i = 0; i < PAT_MAX; i++) begin : g_cell
    cigsm_cell #(
      .IDX (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .pat_byte     (pattern_word[i >> 3][(i & 7) * BYTE_W +: BYTE_W]),
      .chain_in     (chain[i]),
      .lead_in      (lead[i]),
      .en_chain_in  (en_chain[i]),
      .en_right     (en_vec[i+1]),
      .chain_out    (chain[i+1]),
      .lead_out     (lead[i+1]),
      .en_chain_out (en_chain[i+1]),
      .en           (en_vec[i]),
      .tail         (tail[i])
    );
  end

`ifndef NO_ASSERTIONS
  // a name byte without tlast never creates a result
  a_no_result_midname: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !s_tlast && (!m_tvalid || m_tready)) |=> !m_tvalid)
    else $error("result produced without a last byte");

  // after every last byte m_tvalid is high the next cycle
  a_result_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tlast) |=> m_tvalid)
    else $error("missing result after last byte");

  // a known config write blocks name bytes while the chain reloads
  a_cfg_settles: assert property (@(posedge clk) disable iff (rst)
    (cfg_fire && cfg_known) |=> (!s_tready ##1 !s_tready))
    else $error("input accepted during chain reload");

  // enables form a contiguous prefix of the chain
  a_en_prefix: assert property (@(posedge clk) disable iff (rst)
    (settle == 2'd0) |-> ($countones(en_vec[PAT_MAX-1:0] ^ (en_vec[PAT_MAX:1])) <= 1))
    else $error("pattern enables not a prefix");
`endif

endmodule

// File: tb/cigsm_match_checker.sv
// Checker for the case-insensitive glob / substring name matcher: follows the
// config, name and result channels, predicts every match and compares. Uses cigsm_pkg.
`timescale 1ns / 1ps

module cigsm_match_checker import cigsm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [BYTE_W-1:0]    s_tdata,    // [7:0] text_byte
  input  logic                 s_tlast,    // last_byte
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [BYTE_W-1:0]    m_tdata,    // [0] matched, [7:1] zero
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   due_count
);

  logic              wild_mode;
  logic [PLEN_W-1:0] len_reg;
  logic [WORD_W-1:0] pat_words [NUM_PAT_WORDS];
  logic [32:0]       live_set;   // bit i: first i pattern bytes consumed
  logic              hit_seen;
  bit                match_due [$];
  bit                want;

  function automatic logic [BYTE_W-1:0] lower_az(input logic [BYTE_W-1:0] c);
    return (c >= UPPER_A && c <= UPPER_Z) ? (c | CASE_BIT) : c;
  endfunction

  function automatic logic [BYTE_W-1:0] pat_char(input int i);
    return pat_words[i >> 3][(i & 7) * 8 +: 8];
  endfunction

  // length clipped to PAT_MAX and cut at the first NUL
  function automatic int pat_span();
    int n;
    n = (len_reg > PAT_MAX_DEF) ? PAT_MAX_DEF : int'(len_reg);
    for (int i = 0; i < n; i++)
      if (pat_char(i) == NUL_CHAR) return i;
    return n;
  endfunction

  function automatic logic [32:0] close_stars(input logic [32:0] set, input int n);
    for (int i = 0; i < n; i++)
      if (set[i] && pat_char(i) == STAR_CHAR) set[i+1] = 1'b1;
    return set;
  endfunction

  function automatic void restart_name();
    live_set = wild_mode ? close_stars(33'd1, pat_span()) : 33'd1;
    hit_seen = 1'b0;
  endfunction

  function automatic void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [WORD_W-1:0] val);
    case (idx)
      REG_WILDCARD_MODE: wild_mode = val[0];
      REG_PATTERN_LEN:   len_reg = val[PLEN_W-1:0];
      REG_PATTERN_W0:    pat_words[0] = val;
      REG_PATTERN_W1:    pat_words[1] = val;
      REG_PATTERN_W2:    pat_words[2] = val;
      REG_PATTERN_W3:    pat_words[3] = val;
      default:           return;   // unmapped index leaves state alone
    endcase
    restart_name();
  endfunction

  function automatic void advance_positions(input logic [BYTE_W-1:0] b,
                                            input logic is_last);
    logic [BYTE_W-1:0] fc;
    logic [BYTE_W-1:0] p;
    logic [32:0]       nxt;
    int                n;
    fc = lower_az(b);
    n  = pat_span();
    if (wild_mode) begin
      nxt = '0;
      for (int i = 0; i < n; i++) begin
        if (live_set[i]) begin
          p = pat_char(i);
          if (p == STAR_CHAR) nxt[i] = 1'b1;
          else if (p == QMARK_CHAR || lower_az(p) == fc) nxt[i+1] = 1'b1;
        end
      end
      live_set = close_stars(nxt, n);
    end else begin
      nxt = 33'd1;
      for (int i = 0; i < n; i++)
        if (live_set[i] && lower_az(pat_char(i)) == fc) nxt[i+1] = 1'b1;
      if (n > 0 && nxt[n]) hit_seen = 1'b1;
      live_set = nxt;
    end
    if (is_last) begin
      match_due.push_back(wild_mode ? live_set[n] : hit_seen);
      restart_name();
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      wild_mode = 1'b0;
      len_reg   = '0;
      for (int i = 0; i < NUM_PAT_WORDS; i++) pat_words[i] = '0;
      restart_name();
      match_due.delete();
      fail_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (match_due.size() == 0) begin
          $display("%0t: result transfer with none pending, expected none, got matched=%0b",
                   $time, m_tdata[0]);
          fail_count++;
        end else begin
          want = match_due.pop_front();
          if (m_tdata[0] !== want) begin
            $display("%0t: matched mismatch, expected %0b, got %0b", $time, want, m_tdata[0]);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) advance_positions(s_tdata, s_tlast);
    end
    due_count = match_due.size();
  end

endmodule

// File: tb/tb_top.sv
// Top of the name matcher testbench: clock, reset, config and name stimulus,
// result back-pressure and the verdict. Uses cigsm_pkg and cigsm_match_checker.
`timescale 1ns / 1ps

module tb_top import cigsm_pkg::*; ();

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;
  localparam logic [BYTE_W-1:0]    LOWER_A    = 8'h61;
  localparam logic [BYTE_W-1:0]    LOWER_Z    = 8'h7A;
  localparam logic [BYTE_W-1:0]    GRAVE_CHAR = 8'h60;
  localparam string                LETTER_POOL = "abcABC_@[{zZ*?";
  localparam int                   HOLD_CYCLES = 300;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [BYTE_W-1:0]    s_tdata;
  logic                 s_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [BYTE_W-1:0]    m_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;
  int                   fail_count;
  int                   due_count;

  int                   burst_left;
  bit                   sender_idles;
  int                   rx_style;
  int                   hold_asks;   // long hold-offs requested by the stimulus
  int                   hold_done;   // long hold-offs finished by the receiver
  logic [BYTE_W-1:0]    name_buf [$];
  logic [BYTE_W-1:0]    pat_chars [32];
  int                   pat_used;

  case_insensitive_glob_or_substring_match u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cigsm_match_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("Regression FAIL");
    $finish;
  end

  // receiver: per-phase stall pattern, plus one long hold-off on request
  initial begin
    int rx_cyc;
    rx_cyc    = 0;
    hold_done = 0;
    m_tready  = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done++;
      end else begin
        case (rx_style)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 7) != 0);
          default: m_tready <= ((rx_cyc % 7) >= 3);
        endcase
      end
      rx_cyc++;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drop the stream and wait until every result is in and the block is quiet
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_query(input logic mode, input logic [PLEN_W-1:0] len,
                               input logic [255:0] bytes);
    logic [WORD_W-1:0] val;
    settle();
    // junk in the upper bits must be ignored
    val = {$urandom, $urandom};
    val[0] = mode;
    cfg_write(REG_WILDCARD_MODE, val);
    val = {$urandom, $urandom};
    val[PLEN_W-1:0] = len;
    cfg_write(REG_PATTERN_LEN, val);
    cfg_write(REG_PATTERN_W0, bytes[63:0]);
    cfg_write(REG_PATTERN_W1, bytes[127:64]);
    cfg_write(REG_PATTERN_W2, bytes[191:128]);
    cfg_write(REG_PATTERN_W3, bytes[255:192]);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = sender_idles ? $urandom_range(1, 6) : 0;
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= is_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_name();
    for (int i = 0; i < name_buf.size(); i++)
      send_byte(name_buf[i], i == name_buf.size() - 1);
  endtask

  task automatic send_text(input string s);
    name_buf = {};
    for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
    send_name();
  endtask

  function automatic logic [255:0] pack_text(input string s);
    logic [255:0] v;
    v = '0;
    for (int i = 0; i < s.len(); i++) v[i*8 +: 8] = s[i];
    return v;
  endfunction

  function automatic logic [BYTE_W-1:0] literal_char();
    int r;
    r = $urandom_range(0, 15);
    if (r < LETTER_POOL.len()) return LETTER_POOL[r];
    if (r == 14) return GRAVE_CHAR;
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [BYTE_W-1:0] pattern_char(input logic glob);
    int r;
    r = $urandom_range(0, 19);
    if (glob && r < 5) return STAR_CHAR;
    if (glob && r < 8) return QMARK_CHAR;
    return literal_char();
  endfunction

  function automatic logic [BYTE_W-1:0] mixed_case(input logic [BYTE_W-1:0] b);
    if (((b >= UPPER_A && b <= UPPER_Z) || (b >= LOWER_A && b <= LOWER_Z))
        && $urandom_range(0, 1))
      return b ^ CASE_BIT;
    return b;
  endfunction

  // mostly names that fit the pattern up to case, some with one byte spoiled,
  // the rest noise
  task automatic build_name(input logic glob);
    name_buf = {};
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 12)) name_buf.push_back(literal_char());
    end else begin
      if (!glob) repeat ($urandom_range(0, 4)) name_buf.push_back(literal_char());
      for (int i = 0; i < pat_used; i++) begin
        if (glob && pat_chars[i] == STAR_CHAR)
          repeat ($urandom_range(0, 3)) name_buf.push_back(literal_char());
        else if (glob && pat_chars[i] == QMARK_CHAR)
          name_buf.push_back(8'($urandom_range(1, 255)));
        else
          name_buf.push_back(mixed_case(pat_chars[i]));
      end
      if (!glob) repeat ($urandom_range(0, 4)) name_buf.push_back(literal_char());
      if (name_buf.size() > 0 && $urandom_range(0, 4) == 0)
        name_buf[$urandom_range(0, name_buf.size() - 1)] = 8'($urandom_range(1, 255));
    end
    if (name_buf.size() == 0) name_buf.push_back(literal_char());
  endtask

  task automatic random_phase(input int n_bytes, input bit squeeze);
    int                sent;
    int                kind;
    logic              mode;
    logic [PLEN_W-1:0] len_field;
    logic [255:0]      pbits;
    mode = 1'($urandom_range(0, 1));
    kind = $urandom_range(0, 5);
    if (kind == 1) pat_used = 32;
    else if ($urandom_range(0, 7) == 0) pat_used = $urandom_range(7, 32);
    else pat_used = $urandom_range(0, 6);
    for (int i = 0; i < 32; i++) begin
      pat_chars[i] = (i < pat_used) ? pattern_char(mode) : 8'($urandom_range(0, 255));
      pbits[i*8 +: 8] = pat_chars[i];
    end
    len_field = PLEN_W'(pat_used);
    if (kind == 0 && pat_used < 32) begin
      // NUL ends the pattern early even though the length says more
      pbits[pat_used*8 +: 8] = NUL_CHAR;
      len_field = PLEN_W'($urandom_range(pat_used, 63));
    end else if (kind == 1) begin
      len_field = PLEN_W'($urandom_range(32, 63));
    end
    program_query(mode, len_field, pbits);
    sender_idles = ($urandom_range(0, 2) != 0);
    rx_style     = $urandom_range(0, 3);
    if (squeeze) hold_asks++;
    sent = 0;
    while (sent < n_bytes) begin
      build_name(mode);
      send_name();
      sent += name_buf.size();
    end
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tlast      = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    burst_left   = 0;
    sender_idles = 1'b1;
    rx_style     = 2;
    hold_asks    = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers at reset: empty substring pattern finds nothing
    send_text("a");
    // fold only A-Z; '_' and '@' as first chars
    program_query(1'b0, 6'd3, pack_text("_@z"));
    send_text("Q_@Z");
    send_text("_@[");
    program_query(1'b1, 6'd5, pack_text("*.TxT"));
    send_text("a.txt");
    send_text(".TXT");
    send_text("a.tx");
    // '?' takes any byte, including the extremes
    program_query(1'b1, 6'd1, pack_text("?"));
    name_buf = {8'hFF};
    send_name();
    name_buf = {NUL_CHAR};
    send_name();
    // star in the name
    program_query(1'b1, 6'd1, pack_text("*"));
    send_text("*");
    // length above the maximum saturates
    program_query(1'b1, 6'd63, {32{STAR_CHAR}});
    send_text("x");
    // NUL inside the length cuts the pattern
    program_query(1'b0, 6'd5, pack_text("ab"));
    send_text("xAb");
    // empty glob pattern matches no name
    program_query(1'b1, 6'd0, pack_text("abc"));
    send_text("a");
    program_query(1'b0, 6'd2, '1);
    name_buf = {8'hFF, 8'hFF};
    send_name();
    // writes to unmapped indexes change nothing
    settle();
    cfg_write(REG_UNMAPPED_LO, {$urandom, $urandom});
    cfg_write(REG_UNMAPPED_HI, '1);
    send_text("z");
    name_buf = {8'h7F, 8'hFF, 8'hFF};
    send_name();

    for (int ph = 0; ph < 12; ph++) random_phase(75, ph == 2);

    settle();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && due_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: case_insensitive_glob_or_substring_match.f
sv/cigsm_pkg.sv
sv/cigsm_cell.sv
sv/case_insensitive_glob_or_substring_match.sv
tb/cigsm_match_checker.sv
tb/tb_top.sv
